// ----- src/tvn_pkg.sv -----
// Package for the three-vector normaliser: widths, payload types and stage records.
// No dependencies.
package tvn_pkg;
	localparam int COMPONENT_BITS = 16;
	localparam int FRACTION_BITS = 15;
	localparam int MAG_BITS = COMPONENT_BITS;
	localparam int SQ_BITS = 2 * MAG_BITS;
	localparam int SUM_BITS = SQ_BITS + 2;
	localparam int Q_BITS = FRACTION_BITS + 1;
	localparam int OUT_BITS = FRACTION_BITS + 1;
	localparam int NUM_BITS = SQ_BITS + 2 * FRACTION_BITS;
	localparam int QQ_BITS = 2 * Q_BITS;
	localparam int PROD_BITS = QQ_BITS + SUM_BITS;
	localparam int QSUM_BITS = Q_BITS + SUM_BITS;
	localparam int NCOMP = 3;

	typedef struct packed {
		logic signed [COMPONENT_BITS-1:0] comp_x;
		logic signed [COMPONENT_BITS-1:0] comp_y;
		logic signed [COMPONENT_BITS-1:0] comp_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] unit_x;
		logic signed [OUT_BITS-1:0] unit_y;
		logic signed [OUT_BITS-1:0] unit_z;
		logic                       zero_vector;
	} vec_out_t;

	// One digit step: partial quotient per lane with its running q*q*sum and
	// q*sum, shared sum, lane targets.
	typedef struct packed {
		logic [NCOMP-1:0][Q_BITS-1:0]    q;
		logic [NCOMP-1:0][PROD_BITS-1:0] pp;
		logic [NCOMP-1:0][QSUM_BITS-1:0] qsum;
		logic [NCOMP-1:0][NUM_BITS-1:0]  rhs;
		logic [NCOMP-1:0]                neg;
		logic [SUM_BITS-1:0]             sum;
	} step_t;
endpackage

// ----- src/tvn_stream_if.sv -----
// Valid/ready channel interface carrying one payload of a chosen type.
// Depends on nothing beyond the type parameter.
interface tvn_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/tvn_front.sv -----
// Front stages: magnitudes and squares, then sum and digit targets.
// Depends on tvn_pkg.
module tvn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  tvn_pkg::vec_in_t              in_data,
	output logic                          out_valid,
	output tvn_pkg::step_t                out_data
);
	logic [tvn_pkg::NCOMP-1:0][tvn_pkg::MAG_BITS-1:0] mag;
	logic [tvn_pkg::NCOMP-1:0]                        neg;
	logic [tvn_pkg::NCOMP-1:0][tvn_pkg::SQ_BITS-1:0]  sq_s1;
	logic [tvn_pkg::NCOMP-1:0]                        neg_s1;
	logic                                             v_s1;
	logic [tvn_pkg::COMPONENT_BITS-1:0]               raw [tvn_pkg::NCOMP];

	assign raw[0] = in_data.comp_x;
	assign raw[1] = in_data.comp_y;
	assign raw[2] = in_data.comp_z;

	always_comb begin
		for (int i = 0; i < tvn_pkg::NCOMP; i++) begin
			neg[i] = raw[i][tvn_pkg::COMPONENT_BITS-1];
			mag[i] = neg[i] ? (~raw[i] + 1'b1) : raw[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < tvn_pkg::NCOMP; i++) begin
				sq_s1[i] <= mag[i] * mag[i];
				out_data.q[i] <= '0;
				out_data.pp[i] <= '0;
				out_data.qsum[i] <= '0;
				out_data.rhs[i] <= {sq_s1[i], {(2*tvn_pkg::FRACTION_BITS){1'b0}}};
			end
			neg_s1 <= neg;
			out_data.neg <= neg_s1;
			out_data.sum <= tvn_pkg::SUM_BITS'(sq_s1[0]) + tvn_pkg::SUM_BITS'(sq_s1[1])
				+ tvn_pkg::SUM_BITS'(sq_s1[2]);
		end
	end
endmodule

// ----- src/tvn_digit.sv -----
// One restoring square-root-free digit stage: try one quotient bit per lane.
// Depends on tvn_pkg.
module tvn_digit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [4:0]          bit_pos,
	input  logic                in_valid,
	input  tvn_pkg::step_t      in_data,
	output logic                out_valid,
	output tvn_pkg::step_t      out_data
);
	localparam logic [tvn_pkg::Q_BITS-1:0] ONE = tvn_pkg::Q_BITS'(1) << tvn_pkg::FRACTION_BITS;
	logic [tvn_pkg::NCOMP-1:0][tvn_pkg::Q_BITS-1:0]    q_nx;
	logic [tvn_pkg::NCOMP-1:0][tvn_pkg::PROD_BITS-1:0] pp_nx;
	logic [tvn_pkg::NCOMP-1:0][tvn_pkg::QSUM_BITS-1:0] qsum_nx;
	logic [tvn_pkg::Q_BITS-1:0]    cand [tvn_pkg::NCOMP];
	logic [tvn_pkg::PROD_BITS-1:0] pp_try [tvn_pkg::NCOMP];
	logic [tvn_pkg::NCOMP-1:0]     take;

	// (q + 2^b)^2 * sum = q*q*sum + (q*sum << (b+1)) + (sum << 2b): shifts and adds only.
	always_comb begin
		for (int i = 0; i < tvn_pkg::NCOMP; i++) begin
			cand[i] = in_data.q[i] | (tvn_pkg::Q_BITS'(1) << bit_pos);
			pp_try[i] = in_data.pp[i]
				+ (tvn_pkg::PROD_BITS'(in_data.qsum[i]) << (bit_pos + 5'd1))
				+ (tvn_pkg::PROD_BITS'(in_data.sum) << {bit_pos, 1'b0});
			take[i] = (cand[i] <= ONE) &&
				(pp_try[i] <= tvn_pkg::PROD_BITS'(in_data.rhs[i]));
			q_nx[i] = take[i] ? cand[i] : in_data.q[i];
			pp_nx[i] = take[i] ? pp_try[i] : in_data.pp[i];
			qsum_nx[i] = take[i] ?
				in_data.qsum[i] + (tvn_pkg::QSUM_BITS'(in_data.sum) << bit_pos) :
				in_data.qsum[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.q <= q_nx;
			out_data.pp <= pp_nx;
			out_data.qsum <= qsum_nx;
			out_data.rhs <= in_data.rhs;
			out_data.neg <= in_data.neg;
			out_data.sum <= in_data.sum;
		end
	end
endmodule

// ----- src/three_vector_normalize_unit.sv -----
// Three-vector normaliser, fully pipelined: one vector per cycle sustained
// while the output is taken. 2 front stages, 16 digit stages (one quotient
// bit each, tested by shift-and-add updates of q*q*sum), 1 output register.
// Stall: every stage holds while the output register is full and not taken.
// Reset: arst_n clears all valid bits at once; payload is not reset.
module three_vector_normalize_unit (
	input  logic clk,
	input  logic arst_n,
	tvn_stream_if.sink   in_ch,
	tvn_stream_if.source out_ch
);
	localparam int NSTEP = tvn_pkg::Q_BITS;
	logic           adv;
	logic           v   [NSTEP+1];
	tvn_pkg::step_t d   [NSTEP+1];
	tvn_pkg::vec_out_t res_q;
	logic           res_v_q;
	logic signed [tvn_pkg::OUT_BITS-1:0] u [tvn_pkg::NCOMP];
	logic [tvn_pkg::Q_BITS-1:0] qs;
	logic           zero_sum;

	// Advance the whole line unless the output holds an untaken result.
	assign adv = !res_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	tvn_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_ch.valid), .in_data(in_ch.data),
		.out_valid(v[0]), .out_data(d[0])
	);

	// Try quotient bits from the top (bit FRACTION_BITS) downwards.
	for (genvar g = 0; g < NSTEP; g++) begin : g_dig
		tvn_digit u_dig (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.bit_pos(5'(tvn_pkg::FRACTION_BITS - g)),
			.in_valid(v[g]), .in_data(d[g]),
			.out_valid(v[g+1]), .out_data(d[g+1])
		);
	end

	// Saturate +1.0, restore sign. A zero sum lets every lane reach +1.0 in
	// the digit stages, so force the components to zero for a zero vector.
	always_comb begin
		qs = '0;
		zero_sum = (d[NSTEP].sum == '0);
		for (int i = 0; i < tvn_pkg::NCOMP; i++) begin
			qs = d[NSTEP].q[i][tvn_pkg::FRACTION_BITS] ?
				{1'b0, {tvn_pkg::FRACTION_BITS{1'b1}}} : d[NSTEP].q[i];
			if (zero_sum)
				u[i] = '0;
			else
				u[i] = d[NSTEP].neg[i] ? -$signed(qs) : $signed(qs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else if (adv) res_v_q <= v[NSTEP];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.unit_x <= u[0];
			res_q.unit_y <= u[1];
			res_q.unit_z <= u[2];
			res_q.zero_vector <= zero_sum;
		end
	end

	assign out_ch.valid = res_v_q;
	assign out_ch.data = res_q;
endmodule

// ----- sim/three_vector_normalize_unit_tb.sv -----
// Testbench for the three-vector normaliser: directed and random vectors with idle bursts.
// Depends on tvn_pkg, tvn_stream_if and three_vector_normalize_unit.
module three_vector_normalize_unit_tb;
	import tvn_pkg::*;

	logic clk;
	logic arst_n;

	tvn_stream_if #(.payload_t(vec_in_t))  vec_ch (.clk(clk));
	tvn_stream_if #(.payload_t(vec_out_t)) unit_ch (.clk(clk));

	three_vector_normalize_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (vec_ch.sink),
		.out_ch (unit_ch.source)
	);

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_OFF_CYCLES = 200;

	vec_out_t unit_expected_q[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit sink_idle_on = 1'b1;
	bit source_idle_on = 1'b1;
	bit hold_off_req = 1'b0;
	bit timed_out = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Magnitude of a component, exact for the most negative value.
	function automatic logic [COMPONENT_BITS:0] comp_mag(logic signed [COMPONENT_BITS-1:0] c);
		logic signed [COMPONENT_BITS:0] w;
		w = c;
		return (w < 0) ? -w : w;
	endfunction

	// Largest q in Q1.15 with q*q*sum <= mag*mag*2^30, saturated below 1.0.
	function automatic logic signed [OUT_BITS-1:0] unit_of(
		logic signed [COMPONENT_BITS-1:0] c, logic [63:0] sum);
		logic [COMPONENT_BITS:0] m;
		logic [127:0] lim;
		logic [127:0] prod;
		logic [16:0] q;
		logic [16:0] cand;
		logic [OUT_BITS-1:0] r;
		m = comp_mag(c);
		lim = (128'(m) * 128'(m)) << (2 * FRACTION_BITS);
		q = '0;
		for (int b = FRACTION_BITS; b >= 0; b--) begin
			cand = q | (17'd1 << b);
			prod = 128'(cand) * 128'(cand) * 128'(sum);
			if (cand <= (17'd1 << FRACTION_BITS) && prod <= lim)
				q = cand;
		end
		if (q > (17'd1 << FRACTION_BITS) - 1)
			q = (17'd1 << FRACTION_BITS) - 1;
		r = q[OUT_BITS-1:0];
		if (c < 0)
			r = -r;
		return r;
	endfunction

	function automatic vec_out_t normalised_of(vec_in_t v);
		vec_out_t o;
		logic [63:0] sum;
		sum = 64'(comp_mag(v.comp_x)) * comp_mag(v.comp_x)
			+ 64'(comp_mag(v.comp_y)) * comp_mag(v.comp_y)
			+ 64'(comp_mag(v.comp_z)) * comp_mag(v.comp_z);
		o = '0;
		if (sum == 0) begin
			o.zero_vector = 1'b1;
		end else begin
			o.unit_x = unit_of(v.comp_x, sum);
			o.unit_y = unit_of(v.comp_y, sum);
			o.unit_z = unit_of(v.comp_z, sum);
		end
		return o;
	endfunction

	// Offer one vector, hold it until the transfer, then record its expected result.
	task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic signed [15:0] z);
		vec_in_t v;
		int gap;
		v.comp_x = x;
		v.comp_y = y;
		v.comp_z = z;
		if (source_idle_on && $urandom_range(0, 9) == 0) begin
			vec_ch.valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.data <= v;
		do
			@(posedge clk);
		while (!vec_ch.ready);
		unit_expected_q.push_back(normalised_of(v));
		@(negedge clk);
	endtask

	task automatic release_source();
		vec_ch.valid <= 1'b0;
	endtask

	// Random component biased toward the extremes and small values.
	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($signed($urandom_range(0, 6)) - 3);
			3: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_vector(0, 0, 0);
		send_vector(16'sh7fff, 0, 0);
		send_vector(0, 16'sh8000, 0);
		send_vector(0, 0, 1);
		send_vector(0, 0, -1);
		send_vector(-1, 0, 0);
		send_vector(16'sh8000, 16'sh8000, 16'sh8000);
		send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vector(16'sh8000, 16'sh7fff, 0);
		send_vector(1, 1, 1);
		send_vector(3, 4, 0);
		send_vector(-3, 0, 4);
		send_vector(2, -2, 1);
		send_vector(16'sh8000, 1, -1);
		send_vector(1, 16'sh7fff, 16'sh8000);
		send_vector(16'sh5555, 16'shaaaa, 16'sh0f0f);
		send_vector(-16'sd1, -16'sd1, -16'sd1);
		release_source();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++)
			send_vector(rand_comp(), rand_comp(), rand_comp());
		release_source();
	endtask

	// Stall the receiver for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		for (int i = 0; i < 60; i++)
			send_vector(rand_comp(), rand_comp(), rand_comp());
		release_source();
		hold_off_req = 1'b0;
	endtask

	task automatic test_back_to_back(input int n);
		source_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		for (int i = 0; i < n; i++)
			send_vector(16'($urandom), 16'($urandom), 16'($urandom));
		release_source();
	endtask

	// Receiver: random stall bursts, plus a long hold-off counted here.
	initial begin
		int stall;
		unit_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				unit_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_OFF_CYCLES; c++)
					@(negedge clk);
				hold_off_req = 1'b0;
				unit_ch.ready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
				unit_ch.ready <= 1'b0;
				stall = $urandom_range(1, 18);
				repeat (stall - 1) @(negedge clk);
			end else begin
				unit_ch.ready <= 1'b1;
			end
		end
	end

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		vec_out_t want;
		vec_out_t got;
		if (arst_n && unit_ch.valid && unit_ch.ready) begin
			got = unit_ch.data;
			if (unit_expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %p", got);
			end else begin
				want = unit_expected_q.pop_front();
				if (got.unit_x !== want.unit_x || got.unit_y !== want.unit_y
					|| got.unit_z !== want.unit_z || got.zero_vector !== want.zero_vector) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected x=%0d y=%0d z=%0d zero=%0b, got x=%0d y=%0d z=%0d zero=%0b",
							want.unit_x, want.unit_y, want.unit_z, want.zero_vector,
							got.unit_x, got.unit_y, got.unit_z, got.zero_vector);
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((vec_ch.valid && vec_ch.ready) || (unit_ch.valid && unit_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int drain;
		arst_n = 1'b0;
		vec_ch.valid = 1'b0;
		vec_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1200);
		test_backpressure();
		test_random(400);
		test_back_to_back(250);
		drain = 0;
		while (unit_expected_q.size() != 0 && drain < WATCHDOG_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && unit_expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- files.f -----
src/tvn_pkg.sv
src/tvn_stream_if.sv
src/tvn_front.sv
src/tvn_digit.sv
src/three_vector_normalize_unit.sv
sim/three_vector_normalize_unit_tb.sv
